// ----- sv/bpma_pkg.sv -----
// ----------------------------------------------------------------------------
// bpma_pkg
// Shared widths, constants and register codes for the battery percent
// moving-average unit.
// ----------------------------------------------------------------------------
package bpma_pkg;

  localparam int BPMA_WINDOW_DEPTH = 16;

  localparam int ADC_W  = 12;
  localparam int CFG_W  = 12;
  localparam int PCT_W  = 8;
  localparam int OUT_W  = 7;
  localparam int PROD_W = 24;   // 12b x 12b constant products
  localparam int DIV_W  = 32;   // divider remainder / shifted divisor
  localparam int QUO_W  = 8;    // quotient bits, one per divider step after the top one
  localparam int STEP_W = 4;    // counts QUO_W down to 0

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_EMPTY = 1'b0;
  localparam logic REG_SPAN  = 1'b1;

  localparam logic [CFG_W-1:0]  EMPTY_RST      = 12'd1730;
  localparam logic [CFG_W-1:0]  SPAN_RST       = 12'd370;
  localparam logic [CFG_W-1:0]  MV_FULL_SCALE  = 12'd3300;
  localparam logic [CFG_W-1:0]  ADC_FULL_SCALE = 12'd4095;
  localparam logic [OUT_W-1:0]  PCT_MAX        = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_SAT        = 8'd255;
  localparam logic [STEP_W-1:0] DIV_TOP_STEP   = 4'd8;

endpackage

// ----- sv/battery_percent_moving_average_unit.sv -----
// ----------------------------------------------------------------------------
// battery_percent_moving_average_unit
// Converts 12-bit battery converter codes to a charge percent and reports
// the truncated mean of the last WINDOW_DEPTH percents, clamped to 100.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------
//  in      | input     | in_valid/in_stall  | in_adc_sample [11:0]
//  out     | output    | out_valid/out_stall| out_battery_percent [6:0]
//  cfg     | APB slave | psel/penable/pready| empty_level_mv @0, span_mv @4
//
//  One transaction at a time. An accepted sample goes through PREP and, unless
//  it is below the empty level or the span is zero, the percent division; then
//  UPD (ring memory read/modify/write), the mean division and DONE. The single
//  bit-serial divider takes 9 steps for the percent and 9 for the mean.
//  Synchronous active-low reset; ring contents are not cleared, the fill
//  count keeps unwritten slots out of the sum.
//  A new input is taken while a finished result waits in the output register.
// ----------------------------------------------------------------------------
module battery_percent_moving_average_unit
  import bpma_pkg::*;
#(
  parameter int WINDOW_DEPTH = BPMA_WINDOW_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_W-1:0]      in_adc_sample,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_battery_percent,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = $clog2(255 * WINDOW_DEPTH + 1);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIVP = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DIVM = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CFG_W-1:0]  empty_r, empty_nxt;
  logic [CFG_W-1:0]  span_r, span_nxt;
  logic [PROD_W-1:0] scaled_r, scaled_nxt;
  logic [PROD_W-1:0] floor_r, floor_nxt;
  logic [PROD_W-1:0] den_r, den_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dsh_r, dsh_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic [PCT_W-1:0]  pct_r, pct_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_pct_r, out_pct_nxt;

  logic [PCT_W-1:0]  ring_mem [WINDOW_DEPTH];
  logic [PCT_W-1:0]  rd_r;
  logic              ring_we;

  logic              in_acc;
  logic              cfg_wr;
  logic              div_ge;
  logic              ring_full;
  logic [PROD_W-1:0] diff;
  logic [PCT_W-1:0]  old_pct;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign div_ge    = rem_r >= dsh_r;
  assign ring_full = fill_r == FILL_FULL;
  assign diff      = scaled_r - floor_r;
  assign old_pct   = ring_full ? rd_r : '0;

  assign in_stall            = state_r != ST_IDLE;
  assign out_valid           = out_valid_r;
  assign out_battery_percent = out_pct_r;
  assign pready              = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_EMPTY: prdata = APB_DATA_W'(empty_r);
      REG_SPAN:  prdata = APB_DATA_W'(span_r);
      default:   prdata = '0;
    endcase
  end

  // ring memory: one read and one write port, read data registered
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[slot_r] <= pct_r;
    end
    rd_r <= ring_mem[slot_r];
  end

  always_comb begin
    state_nxt     = state_r;
    empty_nxt     = empty_r;
    span_nxt      = span_r;
    scaled_nxt    = scaled_r;
    floor_nxt     = floor_r;
    den_nxt       = den_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    step_nxt      = step_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    pct_nxt       = pct_r;
    out_pct_nxt   = out_pct_r;
    out_valid_nxt = out_valid_r && out_stall;
    ring_we       = 1'b0;

    if (cfg_wr) begin
      case (paddr[2])
        REG_EMPTY: empty_nxt = pwdata[CFG_W-1:0];
        REG_SPAN:  span_nxt  = pwdata[CFG_W-1:0];
        default:   ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          scaled_nxt = PROD_W'(in_adc_sample) * PROD_W'(MV_FULL_SCALE);
          floor_nxt  = PROD_W'(empty_r) * PROD_W'(ADC_FULL_SCALE);
          den_nxt    = PROD_W'(span_r) * PROD_W'(ADC_FULL_SCALE);
          state_nxt  = ST_PREP;
        end
      end

      ST_PREP: begin
        rem_nxt  = DIV_W'(diff) * DIV_W'(PCT_MAX);
        dsh_nxt  = {den_r, {(DIV_W - PROD_W){1'b0}}};
        step_nxt = DIV_TOP_STEP;
        ovf_nxt  = 1'b0;
        if (scaled_r < floor_r) begin
          pct_nxt   = '0;
          state_nxt = ST_UPD;
        end else if (den_r == '0) begin
          pct_nxt   = PCT_SAT;
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_DIVP;
        end
      end

      ST_DIVP, ST_DIVM: begin
        // restoring division, one quotient bit per cycle; top step only
        // detects a quotient of 256 or more
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == DIV_TOP_STEP) begin
          ovf_nxt = div_ge;
        end else begin
          quo_nxt = {quo_r[QUO_W-2:0], div_ge};
          if (div_ge) begin
            rem_nxt = rem_r - dsh_r;
          end
        end
        if (step_r == '0) begin
          if (state_r == ST_DIVP) begin
            pct_nxt   = ovf_r ? PCT_SAT : quo_nxt;
            state_nxt = ST_UPD;
          end else begin
            // mean never exceeds 255, only the clamp to 100 applies
            pct_nxt   = (quo_nxt > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : quo_nxt;
            state_nxt = ST_DONE;
          end
        end
      end

      ST_UPD: begin
        // rd_r holds the slot about to be overwritten
        ring_we  = 1'b1;
        sum_nxt  = sum_r - SUM_W'(old_pct) + SUM_W'(pct_r);
        fill_nxt = ring_full ? fill_r : fill_r + 1'b1;
        slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
        rem_nxt  = DIV_W'(sum_nxt);
        dsh_nxt  = DIV_W'(fill_nxt) << QUO_W;
        step_nxt = DIV_TOP_STEP;
        ovf_nxt  = 1'b0;
        state_nxt = ST_DIVM;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_pct_nxt   = pct_r[OUT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      empty_r     <= EMPTY_RST;
      span_r      <= SPAN_RST;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      empty_r     <= empty_nxt;
      span_r      <= span_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scaled_r  <= scaled_nxt;
    floor_r   <= floor_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    dsh_r     <= dsh_nxt;
    step_r    <= step_nxt;
    quo_r     <= quo_nxt;
    ovf_r     <= ovf_nxt;
    pct_r     <= pct_nxt;
    out_pct_r <= out_pct_nxt;
  end

endmodule

// ----- sv/bpma_checker.sv -----
// ----------------------------------------------------------------------------
// bpma_checker
// Port-level checks for the battery percent moving-average unit.
// ----------------------------------------------------------------------------
module bpma_checker
  import bpma_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [ADC_W-1:0]      in_adc_sample,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [OUT_W-1:0]      out_battery_percent,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [APB_DATA_W-1:0] pwdata,
  input logic [APB_DATA_W-1:0] prdata,
  input logic                  pready
);

  // averaged result is clamped
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_battery_percent <= PCT_MAX)
    else $error("result above 100 percent");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_battery_percent))
    else $error("stalled result changed");

  // one transaction in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input accepted while busy");

  // no result can appear the cycle after an accept from an idle block
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result before processing finished");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind battery_percent_moving_average_unit bpma_checker u_bpma_checker (.*);

// ----- dv/tb_battery_percent_moving_average_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_percent_moving_average_unit
// Self-checking bench for the battery percent moving-average unit. A directed
// table covers reset, sample extremes, zero span and empty-level corners; then
// random phases reprogram both registers over APB and stream samples aimed
// around the empty-to-full band. Each averaged percent is checked against a
// fixed table value or an in-bench model of the scaling, ring and running mean.
// ----------------------------------------------------------------------------
module tb_battery_percent_moving_average_unit;
  import bpma_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [ADC_W-1:0]      in_adc_sample;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_W-1:0]      out_battery_percent;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  battery_percent_moving_average_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_adc_sample       (in_adc_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_battery_percent (out_battery_percent),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // model state
  logic [CFG_W-1:0] empty_mv_cfg;
  logic [CFG_W-1:0] span_mv_cfg;
  logic [PCT_W-1:0] pct_ring [BPMA_WINDOW_DEPTH];
  logic [3:0]       ring_slot;
  int               pct_sum;
  int               held_count;

  logic [OUT_W-1:0] pending_percent [$];
  int               fail_count;
  int               send_idle_pct;
  int               recv_idle_pct;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [OUT_W-1:0] predict_average(input logic [ADC_W-1:0] adc);
    longint unsigned scaled;
    longint unsigned floor_lvl;
    longint unsigned den;
    longint unsigned quo;
    logic [PCT_W-1:0] pct;
    int               mean;
    scaled    = 64'(adc) * 64'(MV_FULL_SCALE);
    floor_lvl = 64'(empty_mv_cfg) * 64'(ADC_FULL_SCALE);
    if (scaled < floor_lvl) begin
      pct = '0;
    end else begin
      den = 64'(span_mv_cfg) * 64'(ADC_FULL_SCALE);
      if (den == 0) begin
        pct = PCT_SAT;
      end else begin
        quo = (scaled - floor_lvl) * 100 / den;
        pct = (quo > PCT_SAT) ? PCT_SAT : quo[PCT_W-1:0];
      end
    end
    // oldest entry drops out once the window is full
    if (held_count >= BPMA_WINDOW_DEPTH) pct_sum -= int'(pct_ring[ring_slot]);
    else held_count++;
    pct_ring[ring_slot] = pct;
    pct_sum += int'(pct);
    ring_slot = ring_slot + 1'b1;
    mean = pct_sum / held_count;
    if (mean > PCT_MAX) mean = int'(PCT_MAX);
    return mean[OUT_W-1:0];
  endfunction

  function automatic void note_error(input string msg);
    if (fail_count < 10) $display("[%0t] ERROR: %s", $realtime, msg);
    fail_count++;
  endfunction

  // fixed_pct < 0: expectation comes from the model
  task automatic send_sample(input logic [ADC_W-1:0] smp, input int fixed_pct);
    logic [OUT_W-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_average(smp);
    pending_percent.push_back(fixed_pct < 0 ? pred : fixed_pct[OUT_W-1:0]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_percent.size() != 0) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic program_reg(input logic sel, input logic [CFG_W-1:0] value,
                             input bit junk_upper);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] rexp;
    wdata = {20'd0, value};
    if (junk_upper) wdata[APB_DATA_W-1:CFG_W] = (APB_DATA_W-CFG_W)'($urandom());
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_EMPTY) empty_mv_cfg = value;
    else span_mv_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rexp = {20'd0, value};
    if (prdata !== rexp)
      note_error($sformatf("readback reg %0d: expected %0d, got %0d", sel, rexp, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: random stall, compare accepted transactions in order
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_percent.size() == 0) begin
        note_error($sformatf("unexpected result %0d", out_battery_percent));
      end else begin
        want = pending_percent.pop_front();
        if (out_battery_percent !== want)
          note_error($sformatf("battery_percent: expected %0d, got %0d",
                               want, out_battery_percent));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  typedef struct {
    bit               is_write;
    logic             reg_sel;
    logic [ADC_W-1:0] value;
    int               fixed_pct;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{1'b0, REG_EMPTY, 12'd0,    0},   // after reset: nothing charged
    '{1'b0, REG_EMPTY, 12'd4095, 100}, // full scale saturates, mean clamps
    '{1'b0, REG_EMPTY, 12'd2147, -1},  // just above the empty level
    '{1'b0, REG_EMPTY, 12'd2146, -1},  // just below it
    '{1'b0, REG_EMPTY, 12'd2606, -1},
    '{1'b0, REG_EMPTY, 12'd2605, -1},
    '{1'b0, REG_EMPTY, 12'd2048, -1},
    '{1'b1, REG_SPAN,  12'd0,    -1},  // zero span
    '{1'b0, REG_EMPTY, 12'd2146, -1},
    '{1'b0, REG_EMPTY, 12'd2147, -1},
    '{1'b1, REG_EMPTY, 12'd0,    -1},
    '{1'b0, REG_EMPTY, 12'd0,    -1},
    '{1'b1, REG_EMPTY, 12'd4095, -1},  // empty level out of reach
    '{1'b0, REG_EMPTY, 12'd4095, -1},
    '{1'b1, REG_SPAN,  12'd4095, -1},
    '{1'b1, REG_EMPTY, 12'd0,    -1},
    '{1'b0, REG_EMPTY, 12'd4095, -1},
    '{1'b0, REG_EMPTY, 12'd1,    -1},
    '{1'b0, REG_EMPTY, 12'd2730, -1},
    '{1'b0, REG_EMPTY, 12'd1365, -1},
    '{1'b1, REG_SPAN,  12'd1,    -1},
    '{1'b0, REG_EMPTY, 12'd3,    -1},  // window fills here
    '{1'b1, REG_EMPTY, 12'd1730, -1},
    '{1'b1, REG_SPAN,  12'd370,  -1}
  };

  initial begin
    int               n_samples;
    int               lo;
    int               hi;
    logic [CFG_W-1:0] new_empty;
    logic [CFG_W-1:0] new_span;
    logic [ADC_W-1:0] smp;

    clk           = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_adc_sample <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    fail_count    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    empty_mv_cfg  = EMPTY_RST;
    span_mv_cfg   = SPAN_RST;
    ring_slot     = '0;
    pct_sum       = 0;
    held_count    = 0;
    foreach (pct_ring[i]) pct_ring[i] = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 45;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        wait_idle();
        program_reg(dir_rows[i].reg_sel, dir_rows[i].value, 1'b0);
      end else begin
        send_sample(dir_rows[i].value, dir_rows[i].fixed_pct);
      end
    end

    for (int ph = 0; ph < 24; ph++) begin
      if (ph < 8) begin
        send_idle_pct = 13;
        recv_idle_pct = 45;
      end else if (ph < 16) begin
        send_idle_pct = 45;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case ($urandom_range(0, 4))
        0:       new_empty = '0;
        1:       new_empty = 12'd4095;
        2:       new_empty = CFG_W'($urandom_range(0, 4095));
        default: new_empty = CFG_W'($urandom_range(1000, 3000));
      endcase
      case ($urandom_range(0, 5))
        0:       new_span = '0;
        1:       new_span = 12'd1;
        2:       new_span = 12'd4095;
        3:       new_span = CFG_W'($urandom_range(0, 4095));
        default: new_span = CFG_W'($urandom_range(50, 600));
      endcase
      wait_idle();
      program_reg(REG_EMPTY, new_empty, $urandom_range(0, 3) == 0);
      program_reg(REG_SPAN,  new_span,  $urandom_range(0, 3) == 0);

      // codes around the band between empty and full
      lo = (int'(empty_mv_cfg) * 4095) / 3300 - 8;
      hi = ((int'(empty_mv_cfg) + int'(span_mv_cfg)) * 4095) / 3300 + 9;
      if (lo < 0) lo = 0;
      if (lo > 4095) lo = 4095;
      if (hi > 4095) hi = 4095;
      if (hi < lo) hi = lo;

      n_samples = $urandom_range(40, 68);
      for (int k = 0; k < n_samples; k++) begin
        case ($urandom_range(0, 7))
          0:       smp = '0;
          1:       smp = 12'd4095;
          2, 3:    smp = ADC_W'($urandom_range(0, 4095));
          default: smp = ADC_W'($urandom_range(lo, hi));
        endcase
        send_sample(smp, -1);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
